>>> hdl/gre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gre_pkg;

    localparam int CODE_W  = 5;
    localparam int VALUE_W = 17;
    localparam int N_EVENTS = 17;

    localparam logic [CODE_W-1:0] CODE_HAT_Y   = 5'd0;
    localparam logic [CODE_W-1:0] CODE_START   = 5'd1;
    localparam logic [CODE_W-1:0] CODE_BACK    = 5'd2;
    localparam logic [CODE_W-1:0] CODE_THUMB_L = 5'd3;
    localparam logic [CODE_W-1:0] CODE_THUMB_R = 5'd4;
    localparam logic [CODE_W-1:0] CODE_TL      = 5'd5;
    localparam logic [CODE_W-1:0] CODE_TR      = 5'd6;
    localparam logic [CODE_W-1:0] CODE_MODE    = 5'd7;
    localparam logic [CODE_W-1:0] CODE_SOUTH   = 5'd8;
    localparam logic [CODE_W-1:0] CODE_EAST    = 5'd9;
    localparam logic [CODE_W-1:0] CODE_NORTH   = 5'd10;
    localparam logic [CODE_W-1:0] CODE_WEST    = 5'd11;
    localparam logic [CODE_W-1:0] CODE_Y       = 5'd12;
    localparam logic [CODE_W-1:0] CODE_RX      = 5'd13;
    localparam logic [CODE_W-1:0] CODE_RY      = 5'd14;
    localparam logic [CODE_W-1:0] CODE_X       = 5'd15;
    localparam logic [CODE_W-1:0] CODE_SYNC    = 5'd16;

    // Register byte addresses (bit 2 selects the register).
    localparam logic REG_DEADZONE = 1'b0;

    localparam logic [14:0] DEADZONE_RESET = 15'd6;

    // One classified report: which events are due and the values they carry.
    typedef struct packed {
        logic [N_EVENTS-1:0]       mask;
        logic [7:0]                buttons_a;
        logic [7:0]                buttons_b;
        logic signed [VALUE_W-1:0] y_value;
        logic signed [VALUE_W-1:0] rx_value;
        logic signed [VALUE_W-1:0] ry_value;
        logic signed [VALUE_W-1:0] x_value;
    } gre_job_t;

    // raw * 32767 / 255 = raw * 128 + raw * 127 / 255; the last quotient uses
    // the divide-by-255 identity (v + (v >> 8) + 1) >> 8, exact for v < 65535.
    function automatic logic [14:0] scale_trigger(input logic [7:0] raw);
        logic [14:0] prod;
        logic [15:0] sum;
        prod = {raw, 7'b0} - {7'b0, raw};
        sum  = {1'b0, prod} + {9'b0, prod[14:8]} + 16'd1;
        return {raw, 7'b0} + {7'b0, sum[15:8]};
    endfunction

endpackage

`default_nettype wire

>>> hdl/gamepad_report_to_events_core.sv
// Gamepad report to input events.
// Input stream (s_tvalid/s_tready/s_tdata): one transfer per report, fields
// packed from bit 0: buttons_a[7:0], buttons_b[15:8], trigger_left_raw[23:16],
// trigger_right_raw[31:24], left_y_raw[47:32], right_x_raw[63:48],
// right_y_raw[79:64].
// Output stream (m_tvalid/m_tready/m_tdata/m_tlast): one transfer per event,
// event_code in [4:0], signed event_value in [21:5]; m_tlast marks the sync
// event that closes each report.
// The front classifies a report in its accept cycle against the stored
// previous report and pushes a job into a short queue; the back walks the
// job's pending events into an output register, one event per cycle while
// the receiver takes them. The first event of a report passes through a
// queue slot, the back's job register and the output register. A report
// brings 1 to 17 events (every event of a changed group, plus the sync).
// Reports are taken back to back while the queue has room.
// A receiver stall holds the output register and the walk; the queue then
// fills and s_tready drops. Reset clears the history (buttons zero, sticks
// and virtual X at center), empties the queue and sets deadzone to 6.
// Config: APB, deadzone at byte address 0, written on psel&penable&pwrite.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_report_to_events_core
    import gre_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // reports in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // buttons_a, buttons_b, trigger_left_raw,
                                        // trigger_right_raw, left_y_raw,
                                        // right_x_raw, right_y_raw
    // events out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // event_code, event_value, zero pad
    output logic             m_tlast
);

    logic [14:0] deadzone_reg;
    logic        cfg_write;

    logic        push;
    gre_job_t    push_job;
    logic        queue_full;
    logic        pop;
    gre_job_t    pop_job;
    logic        queue_not_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // Only the deadzone register exists; other addresses read zero.
    assign prdata    = (paddr[2] == REG_DEADZONE) ? {17'b0, deadzone_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= DEADZONE_RESET;
        end
        else if (cfg_write && paddr[2] == REG_DEADZONE)
        begin
            deadzone_reg <= pwdata[14:0];
        end
    end

    gre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .deadzone   (deadzone_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    gre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_job   (pop_job),
        .not_empty (queue_not_empty)
    );

    gre_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_job       (pop_job),
        .pop             (pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/gre_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gre_front
    import gre_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic [14:0] deadzone,
    input  wire logic        queue_full,
    output logic             push,
    output gre_job_t         push_job
);

    logic [7:0]  ba;
    logic [7:0]  bb;
    logic [7:0]  tl_raw;
    logic [7:0]  tr_raw;
    logic [15:0] ly_raw;
    logic [15:0] rx_raw;
    logic [15:0] ry_raw;

    logic [7:0]  last_ba_reg;
    logic [7:0]  last_bb_reg;
    logic [15:0] last_ly_reg;
    logic [15:0] last_rx_reg;
    logic [15:0] last_ry_reg;
    logic signed [VALUE_W-1:0] last_vx_reg;
    logic signed [VALUE_W-1:0] last_vx_next;

    logic [14:0] scaled_l;
    logic [14:0] scaled_r;
    logic signed [VALUE_W-1:0] diff;
    logic [VALUE_W-1:0] mag;

    assign ba     = s_tdata[7:0];
    assign bb     = s_tdata[15:8];
    assign tl_raw = s_tdata[23:16];
    assign tr_raw = s_tdata[31:24];
    assign ly_raw = s_tdata[47:32];
    assign rx_raw = s_tdata[63:48];
    assign ry_raw = s_tdata[79:64];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    assign scaled_l = scale_trigger(tl_raw);
    assign scaled_r = scale_trigger(tr_raw);
    assign diff     = $signed({2'b00, scaled_r}) - $signed({2'b00, scaled_l});
    assign mag      = diff[VALUE_W-1] ? 17'(-diff) : diff;

    always_comb
    begin
        // Left wins over right on the d-pad.
        if (ba[2])
        begin
            last_vx_next = -17'sd32768;
        end
        else if (ba[3])
        begin
            last_vx_next = 17'sd32767;
        end
        else if (mag <= {2'b00, deadzone})
        begin
            last_vx_next = '0;
        end
        else
        begin
            last_vx_next = diff;
        end
    end

    always_comb
    begin
        push_job.buttons_a = ba;
        push_job.buttons_b = bb;
        // Offset removal is a flip of the top bit; Y axes are negated.
        push_job.y_value   = 17'sd0 - $signed({~ly_raw[15], ~ly_raw[15], ly_raw[14:0]});
        push_job.rx_value  = $signed({~rx_raw[15], ~rx_raw[15], rx_raw[14:0]});
        push_job.ry_value  = 17'sd0 - $signed({~ry_raw[15], ~ry_raw[15], ry_raw[14:0]});
        push_job.x_value   = last_vx_next;
        push_job.mask[4:0]  = {5{ba != last_ba_reg}};
        push_job.mask[11:5] = {7{bb != last_bb_reg}};
        push_job.mask[12]   = ly_raw != last_ly_reg;
        push_job.mask[13]   = rx_raw != last_rx_reg;
        push_job.mask[14]   = ry_raw != last_ry_reg;
        push_job.mask[15]   = last_vx_next != last_vx_reg;
        push_job.mask[16]   = 1'b1;
    end

    // Stick history is kept raw; a signed zero is the raw midpoint.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ba_reg <= '0;
            last_bb_reg <= '0;
            last_ly_reg <= 16'h8000;
            last_rx_reg <= 16'h8000;
            last_ry_reg <= 16'h8000;
            last_vx_reg <= '0;
        end
        else if (push)
        begin
            last_ba_reg <= ba;
            last_bb_reg <= bb;
            last_ly_reg <= ly_raw;
            last_rx_reg <= rx_raw;
            last_ry_reg <= ry_raw;
            last_vx_reg <= last_vx_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gre_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gre_queue
    import gre_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire gre_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output gre_job_t      pop_job,
    output logic          not_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gre_job_t           slot_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg;
    logic [IDX_W-1:0]   wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [IDX_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue read while empty");

endmodule

`default_nettype wire

>>> hdl/gre_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gre_back
    import gre_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        queue_not_empty,
    input  wire gre_job_t    queue_job,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    gre_job_t            job_reg;
    gre_job_t            job_next;
    logic [N_EVENTS-1:0] mask_after;
    logic [CODE_W-1:0]   code;
    logic signed [VALUE_W-1:0] value;
    logic                out_free;
    logic                emit;

    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_last_reg;

    // Lowest pending event goes first.
    always_comb
    begin
        code = CODE_SYNC;
        for (int i = N_EVENTS - 1; i >= 0; i--)
        begin
            if (job_reg.mask[i])
            begin
                code = CODE_W'(i);
            end
        end
    end

    assign mask_after = job_reg.mask & ~(N_EVENTS'(1) << code);

    always_comb
    begin
        case (code)
            CODE_HAT_Y:   value = job_reg.buttons_a[1] ? 17'sd1
                                : (job_reg.buttons_a[0] ? -17'sd1 : 17'sd0);
            CODE_START:   value = {16'b0, job_reg.buttons_a[4]};
            CODE_BACK:    value = {16'b0, job_reg.buttons_a[5]};
            CODE_THUMB_L: value = {16'b0, job_reg.buttons_a[6]};
            CODE_THUMB_R: value = {16'b0, job_reg.buttons_a[7]};
            CODE_TL:      value = {16'b0, job_reg.buttons_b[0]};
            CODE_TR:      value = {16'b0, job_reg.buttons_b[1]};
            CODE_MODE:    value = {16'b0, job_reg.buttons_b[2]};
            CODE_SOUTH:   value = {16'b0, job_reg.buttons_b[4]};
            CODE_EAST:    value = {16'b0, job_reg.buttons_b[5]};
            CODE_NORTH:   value = {16'b0, job_reg.buttons_b[6]};
            CODE_WEST:    value = {16'b0, job_reg.buttons_b[7]};
            CODE_Y:       value = job_reg.y_value;
            CODE_RX:      value = job_reg.rx_value;
            CODE_RY:      value = job_reg.ry_value;
            CODE_X:       value = job_reg.x_value;
            default:      value = '0;
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (job_reg.mask != '0) && out_free;
    // Load the next report while the back is idle, or as the current one hands over its sync.
    assign pop      = queue_not_empty && ((job_reg.mask == '0) || (emit && mask_after == '0));

    always_comb
    begin
        job_next = job_reg;
        if (pop)
        begin
            job_next = queue_job;
        end
        else if (emit)
        begin
            job_next.mask = mask_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_reg <= job_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_code_reg  <= code;
            out_value_reg <= value;
            out_last_reg  <= code == CODE_SYNC;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_code_reg};
    assign m_tlast  = out_last_reg;

    a_sync_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (job_reg.mask != '0) |-> job_reg.mask[CODE_SYNC])
        else $error("active report lost its sync");

    a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_code_reg == CODE_SYNC)))
        else $error("tlast does not match sync event");

endmodule

`default_nettype wire

>>> tb/tb_gamepad_report_to_events_core.sv
`timescale 1ns / 1ps

// Checks the gamepad report to event converter against a behavioral predictor.
// Each report accepted on the input stream is classified against the previous
// report, and the events it must produce go onto a queue. Every event transfer
// on the output stream is matched against the oldest queued event, field by
// field. The deadzone register is written over APB only while the block is
// drained, and it is read back after every write.
module tb_gamepad_report_to_events_core
    import gre_pkg::*;
;

    localparam int HALF_PERIOD     = 2;
    localparam int IDLE_PCT        = 29;    // chance of a sender gap or receiver stall
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall for the backpressure test
    localparam int STALL_LIMIT     = 4000;  // cycles without any transfer before giving up
    localparam int SETTLE_CYCLES   = 20;    // quiet cycles after the last expected event
    localparam int CENTER          = 32768;
    localparam int RANDOM_PHASE    = 90;

    localparam logic [2:0] ADDR_DEADZONE = {REG_DEADZONE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = {~REG_DEADZONE, 2'b00};

    // Packed so that the struct maps straight onto s_tdata: buttons_a sits in
    // the low byte, right_y in the top 16 bits.
    typedef struct packed {
        logic [15:0] right_y;
        logic [15:0] right_x;
        logic [15:0] left_y;
        logic [7:0]  trig_r;
        logic [7:0]  trig_l;
        logic [7:0]  buttons_b;
        logic [7:0]  buttons_a;
    } report_t;

    typedef struct packed {
        logic [CODE_W-1:0]         code;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } pad_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;     // buttons_a, buttons_b, trigger_left_raw,
                                   // trigger_right_raw, left_y_raw, right_x_raw,
                                   // right_y_raw
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // event_code, event_value, zero pad
    logic        m_tlast;

    // Events the block still owes, oldest first.
    pad_event_t pending_events[$];

    // Predictor copy of the history and the deadzone setting.
    logic [7:0]  prev_a;
    logic [7:0]  prev_b;
    int          prev_ly;
    int          prev_rx;
    int          prev_ry;
    int          prev_vx;
    logic [14:0] dz_setting;

    report_t last_sent;
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      no_idle = 1'b0;       // suppress sender gaps and receiver stalls
    bit      sink_held = 1'b0;     // receiver forced off by the hold-off process
    event    hold_off_go;

    gamepad_report_to_events_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Trigger bytes scale to 0..32767 with truncation.
    function automatic int trigger_scaled(input logic [7:0] raw);
        return int'(raw) * 32767 / 255;
    endfunction

    task automatic expect_event(input logic [CODE_W-1:0] code, input int value,
                                input logic last);
        pad_event_t ev;
        ev.code  = code;
        ev.value = value[VALUE_W-1:0];
        ev.last  = last;
        pending_events.push_back(ev);
    endtask

    // Queue the events one accepted report must produce and advance the history.
    task automatic predict_report(input report_t r);
        int ly;
        int rx;
        int ry;
        int vx;
        int diff;
        ly = int'(r.left_y) - CENTER;
        rx = int'(r.right_x) - CENTER;
        ry = int'(r.right_y) - CENTER;

        // Hat: down beats up when both are held.
        if (r.buttons_a != prev_a)
        begin
            expect_event(CODE_HAT_Y, r.buttons_a[1] ? 1 : (r.buttons_a[0] ? -1 : 0), 1'b0);
            for (int i = 0; i < 4; i++)
                expect_event(CODE_W'(CODE_START + i), r.buttons_a[4 + i], 1'b0);
        end
        // Bit 3 of buttons_b has no event of its own but still counts as a change.
        if (r.buttons_b != prev_b)
        begin
            for (int i = 0; i < 7; i++)
                expect_event(CODE_W'(CODE_TL + i), r.buttons_b[i < 3 ? i : i + 1], 1'b0);
        end
        // Both Y axes are negated; raw 0 gives +32768, which still fits.
        if (ly != prev_ly)
            expect_event(CODE_Y, -ly, 1'b0);
        if (rx != prev_rx)
            expect_event(CODE_RX, rx, 1'b0);
        if (ry != prev_ry)
            expect_event(CODE_RY, -ry, 1'b0);

        // Virtual X: d-pad left wins over right, else the trigger difference
        // outside the deadzone.
        if (r.buttons_a[2])
            vx = -32768;
        else if (r.buttons_a[3])
            vx = 32767;
        else
        begin
            diff = trigger_scaled(r.trig_r) - trigger_scaled(r.trig_l);
            vx = (((diff < 0) ? -diff : diff) <= int'(dz_setting)) ? 0 : diff;
        end
        if (vx != prev_vx)
        begin
            expect_event(CODE_X, vx, 1'b0);
            prev_vx = vx;
        end

        expect_event(CODE_SYNC, 0, 1'b1);

        prev_a  = r.buttons_a;
        prev_b  = r.buttons_b;
        prev_ly = ly;
        prev_rx = rx;
        prev_ry = ry;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Match every event transfer against the oldest owed event.
    always @(posedge clk)
    begin
        pad_event_t want;
        logic [CODE_W-1:0]         got_code;
        logic signed [VALUE_W-1:0] got_value;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_code  = m_tdata[CODE_W-1:0];
            got_value = m_tdata[CODE_W +: VALUE_W];
            if (pending_events.size() == 0)
                report_mismatch("unexpected event, code", -1, int'(got_code));
            else
            begin
                want = pending_events.pop_front();
                if (got_code != want.code)
                    report_mismatch("event_code", int'(want.code), int'(got_code));
                if (got_value != want.value)
                    report_mismatch("event_value", int'(want.value), int'(got_value));
                if (m_tlast != want.last)
                    report_mismatch("last_event", int'(want.last), int'(m_tlast));
            end
        end
    end

    // Give up when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Stall at random unless a no-idle stretch or a hold-off is running.
    always @(posedge clk)
    begin
        if (sink_held)
            m_tready <= 1'b0;
        else if (no_idle)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // Hold the receiver off for a long stretch on request; the sender keeps
    // offering reports so the internal queue fills and s_tready drops.
    initial
    begin
        forever
        begin
            @(hold_off_go);
            sink_held <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            sink_held <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender side and configuration
    // ------------------------------------------------------------------

    // Offer one report, with a random gap first, and predict it once transferred.
    task automatic send_report(input report_t r);
        while (!no_idle && $urandom_range(99, 0) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do
            @(posedge clk);
        while (!s_tready);
        predict_report(r);
        last_sent = r;
    endtask

    // Drop valid and wait until every owed event has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_DEADZONE)
            dz_setting = data[14:0];
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_deadzone_readback();
        logic [31:0] got;
        apb_read(ADDR_DEADZONE, got);
        if (got != {17'b0, dz_setting})
            report_mismatch("deadzone readback", int'(dz_setting), int'(got));
    endtask

    // Write the deadzone on a drained block, then read it back.
    task automatic set_deadzone(input int value);
        wait_drained();
        apb_write(ADDR_DEADZONE, value);
        check_deadzone_readback();
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic report_t make_report(input logic [7:0] ba, input logic [7:0] bb,
                                            input logic [7:0] tl, input logic [7:0] tr,
                                            input logic [15:0] ly, input logic [15:0] rx,
                                            input logic [15:0] ry);
        report_t r;
        r.buttons_a = ba;
        r.buttons_b = bb;
        r.trig_l    = tl;
        r.trig_r    = tr;
        r.left_y    = ly;
        r.right_x   = rx;
        r.right_y   = ry;
        return r;
    endfunction

    // Keep, flip one bit, or replace: keeps changes sparse so that reports
    // with few events mix with reports that change whole groups.
    function automatic logic [7:0] mutate_byte(input logic [7:0] prev);
        logic [7:0] v;
        logic [2:0] bit_idx;
        v = prev;
        bit_idx = 3'($urandom_range(7, 0));
        case ($urandom_range(2, 0))
            1: v[bit_idx] = ~v[bit_idx];
            2: v = 8'($urandom);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] mutate_axis(input logic [15:0] prev);
        logic [15:0] v;
        v = prev;
        case ($urandom_range(4, 0))
            2:
            begin
                case ($urandom_range(3, 0))
                    0: v = 16'h0000;
                    1: v = 16'hFFFF;
                    2: v = 16'h8000;
                    default: v = 16'h7FFF;
                endcase
            end
            3, 4: v = 16'($urandom);
            default: ;
        endcase
        return v;
    endfunction

    function automatic report_t random_report(input report_t prev);
        report_t r;
        r = prev;
        r.buttons_a = mutate_byte(prev.buttons_a);
        r.buttons_b = mutate_byte(prev.buttons_b);
        if ($urandom_range(1, 0))
        begin
            r.trig_l = 8'($urandom);
            // Keep the triggers close now and then to land near the deadzone edge.
            if ($urandom_range(3, 0) == 0)
                r.trig_r = r.trig_l + 8'($urandom_range(2, 0));
            else
                r.trig_r = 8'($urandom);
        end
        r.left_y  = mutate_axis(prev.left_y);
        r.right_x = mutate_axis(prev.right_x);
        r.right_y = mutate_axis(prev.right_y);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Deadzone resets to 6; a centered report repeats the reset history and
    // must give only a sync, as must the same report again.
    task automatic test_reset_state();
        report_t centered;
        check_deadzone_readback();
        centered = make_report(8'h00, 8'h00, 8'h00, 8'h00, 16'h8000, 16'h8000, 16'h8000);
        send_report(centered);
        send_report(centered);
    endtask

    task automatic test_field_extremes();
        // All zero: Y reads +32768, RX -32768, RY +32768.
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000));
        // All ones: down wins the hat, left wins virtual X.
        send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Only the unused bit of buttons_b changes: the whole group is still sent.
        send_report(make_report(8'hFF, 8'hF7, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Up alone, then down alone, then both.
        send_report(make_report(8'h01, 8'hF7, 8'hFF, 8'hFF, 16'h7FFF, 16'h8001, 16'h7FFF));
        send_report(make_report(8'h02, 8'hF7, 8'hFF, 8'hFF, 16'h7FFF, 16'h8001, 16'h7FFF));
        send_report(make_report(8'h03, 8'h00, 8'hFF, 8'hFF, 16'h8001, 16'h7FFF, 16'h8001));
        // Right alone, then left and right together.
        send_report(make_report(8'h08, 8'h00, 8'h00, 8'h00, 16'h8001, 16'h7FFF, 16'h8001));
        send_report(make_report(8'h0C, 8'h00, 8'h00, 8'h00, 16'h8001, 16'h7FFF, 16'h8001));
        // Full triggers each way with the d-pad released.
        send_report(make_report(8'hF0, 8'h00, 8'h00, 8'hFF, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(8'hF0, 8'h00, 8'hFF, 8'h00, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 16'h8000, 16'h8000, 16'h8000));
    endtask

    // One raw trigger step scales to 128: just outside a deadzone of 127,
    // just inside 128.
    task automatic test_deadzone_edges();
        set_deadzone(127);
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h01, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(8'h00, 8'h00, 8'h01, 8'h00, 16'h8000, 16'h8000, 16'h8000));
        set_deadzone(128);
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h01, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(8'h00, 8'h00, 8'h01, 8'h00, 16'h8000, 16'h8000, 16'h8000));
        set_deadzone(0);
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h01, 16'h8000, 16'h8000, 16'h8000));
        set_deadzone(32767);
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'hFF, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(8'h00, 8'h00, 8'hFF, 8'h00, 16'h8000, 16'h8000, 16'h8000));
    endtask

    // A write to an address with no register must leave the deadzone alone.
    task automatic test_unmapped_register();
        set_deadzone(6);
        apb_write(ADDR_UNMAPPED, 32'h0000_1234);
        check_deadzone_readback();
    endtask

    // Hold the receiver off while the sender streams without gaps.
    task automatic test_receiver_hold_off();
        wait_drained();
        no_idle = 1'b1;
        -> hold_off_go;
        repeat (30)
            send_report(random_report(last_sent));
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Random reports over several deadzone settings; one phase runs without
    // any idling on either side.
    task automatic test_random_reports();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_deadzone($urandom_range(400, 0));
                1: set_deadzone(0);
                2: set_deadzone(32767);
                default: set_deadzone(6);
            endcase
            no_idle = (phase == 1);
            repeat (RANDOM_PHASE)
                send_report(random_report(last_sent));
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    initial
    begin
        prev_a     = '0;
        prev_b     = '0;
        prev_ly    = 0;
        prev_rx    = 0;
        prev_ry    = 0;
        prev_vx    = 0;
        dz_setting = DEADZONE_RESET;
        last_sent  = make_report(8'h00, 8'h00, 8'h00, 8'h00, 16'h8000, 16'h8000, 16'h8000);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_deadzone_edges();
        test_unmapped_register();
        test_receiver_hold_off();
        test_random_reports();

        // Let any stray event show up before the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
